// ----- rtl/dlms_pkg.sv -----
package dlms_pkg;

    typedef enum logic [3:0] {
        MODE_IDLE    = 4'd0,
        MODE_PREPARE = 4'd1,
        MODE_DOWN    = 4'd2,
        MODE_UP      = 4'd3,
        MODE_STOP    = 4'd4,
        MODE_DONE    = 4'd5,
        MODE_RCPREP  = 4'd6,
        MODE_RCRUN   = 4'd7,
        MODE_RCDONE  = 4'd8
    } mode_t;

    typedef enum logic [2:0] {
        CMD_IDLE     = 3'd0,
        CMD_PREMOVE  = 3'd1,
        CMD_LOWER    = 3'd2,
        CMD_RAISE    = 3'd3,
        CMD_OK       = 3'd4,
        CMD_FINISH   = 3'd5,
        CMD_CALBEGIN = 3'd6,
        CMD_CALEND   = 3'd7
    } cmd_t;

    localparam logic [1:0] FUNC_POLL   = 2'd0;
    localparam logic [1:0] FUNC_TARGET = 2'd1;
    localparam logic [1:0] FUNC_RECAL  = 2'd2;

    localparam logic [2:0] REG_LOWEST    = 3'd0;
    localparam logic [2:0] REG_HIGHEST   = 3'd1;
    localparam logic [2:0] REG_OVERSHOOT = 3'd2;
    localparam logic [2:0] REG_SPAN      = 3'd3;
    localparam logic [2:0] REG_TIMEOUT   = 3'd4;

    localparam logic [15:0] LOWEST_RESET    = 16'd150;
    localparam logic [15:0] HIGHEST_RESET   = 16'd6500;
    localparam logic [9:0]  OVERSHOOT_RESET = 10'd30;
    localparam logic [11:0] SPAN_RESET      = 12'd400;
    localparam logic [15:0] TIMEOUT_RESET   = 16'd256;

    localparam logic [7:0]  STAT_IDLE_A  = 8'h25;
    localparam logic [7:0]  STAT_IDLE_B  = 8'h60;
    localparam logic [7:0]  STAT_HOMED   = 8'h01;
    localparam logic [15:0] RECAL_HEIGHT = 16'd99;
    localparam logic [15:0] TARGET_NONE  = 16'hFFFF;

    typedef struct packed {
        logic [15:0] lowest;
        logic [15:0] highest;
        logic [9:0]  overshoot;
        logic [11:0] span;
        logic [15:0] timeout;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] now_ms;
        logic        left_ok;
        logic [15:0] left_position;
        logic [7:0]  left_status;
        logic        right_ok;
        logic [15:0] right_position;
        logic [7:0]  right_status;
        logic [15:0] new_target;
    } item_t;

    typedef struct packed {
        mode_t       mode;
        logic        pending;
        logic [15:0] target;
        logic [15:0] left_pos;
        logic [15:0] right_pos;
        logic [7:0]  left_stat;
        logic [7:0]  right_stat;
        logic [31:0] last_move_ms;
    } state_t;

    typedef struct packed {
        logic        cmd_valid;
        cmd_t        cmd_code;
        logic [15:0] cmd_position;
        logic        alert;
        mode_t       mode;
        logic        move_pending;
        logic [15:0] target_now;
    } result_t;

endpackage

// ----- rtl/dlms_step.sv -----
module dlms_step (
    input  dlms_pkg::item_t   item,
    input  dlms_pkg::state_t  state,
    input  dlms_pkg::cfg_t    cfg,
    output dlms_pkg::state_t  state_next,
    output dlms_pkg::result_t result
);

    function automatic logic stat_idle(input logic [7:0] s);
        stat_idle = (s == 8'd0) || (s == dlms_pkg::STAT_IDLE_A) || (s == dlms_pkg::STAT_IDLE_B);
    endfunction

    logic        poll;
    logic        step;
    logic        moved;
    logic [15:0] lpos_u;
    logic [15:0] rpos_u;
    logic [7:0]  lstat_u;
    logic [7:0]  rstat_u;
    logic [31:0] last_u;
    logic [15:0] pos_lo;
    logic [15:0] pos_hi;
    logic        idle_u;
    logic        idle_s;
    logic        below;
    logic        above;
    logic        dn_ok;
    logic        up_ok;
    logic [15:0] target_adj;
    logic [31:0] elapsed;
    logic        timed_out;
    logic        down_stop;
    logic        up_stop;
    logic        rc_done;
    logic [16:0] lo_span;
    logic [16:0] lowest_span;
    logic [15:0] clamp_top;
    logic [15:0] clamp_bot;
    logic [15:0] clamped;

    // Leg update: answering legs overwrite their stored values before the step.
    assign poll    = (item.func == dlms_pkg::FUNC_POLL);
    assign step    = poll && item.left_ok && item.right_ok;
    assign lpos_u  = (poll && item.left_ok) ? item.left_position : state.left_pos;
    assign rpos_u  = (poll && item.right_ok) ? item.right_position : state.right_pos;
    assign lstat_u = (poll && item.left_ok) ? item.left_status : state.left_stat;
    assign rstat_u = (poll && item.right_ok) ? item.right_status : state.right_stat;
    assign moved   = poll && ((item.left_ok && (item.left_position != state.left_pos)) ||
                              (item.right_ok && (item.right_position != state.right_pos)));
    assign last_u  = moved ? item.now_ms : state.last_move_ms;

    assign pos_lo = (lpos_u < rpos_u) ? lpos_u : rpos_u;
    assign pos_hi = (lpos_u > rpos_u) ? lpos_u : rpos_u;
    assign idle_u = stat_idle(lstat_u) && stat_idle(rstat_u);
    assign idle_s = stat_idle(state.left_stat) && stat_idle(state.right_stat);

    assign below = (state.target < pos_lo);
    assign above = (state.target > pos_hi);
    assign dn_ok = ({1'b0, state.target} >= ({1'b0, cfg.lowest} + {7'd0, cfg.overshoot}));
    assign up_ok = (({1'b0, state.target} + {7'd0, cfg.overshoot}) <= {1'b0, cfg.highest});

    // The overshoot only applies on the prepare step, in the direction of travel.
    always_comb
    begin
        target_adj = state.target;
        if (state.mode == dlms_pkg::MODE_PREPARE)
        begin
            if (below)
            begin
                if (dn_ok)
                begin
                    target_adj = state.target - {6'd0, cfg.overshoot};
                end
            end
            else if (above && up_ok)
            begin
                target_adj = state.target + {6'd0, cfg.overshoot};
            end
        end
    end

    assign elapsed   = item.now_ms - last_u;
    assign timed_out = (elapsed > {16'd0, cfg.timeout});
    assign down_stop = (state.target >= pos_lo) || timed_out;
    assign up_stop   = (state.target <= pos_hi) || timed_out;
    assign rc_done   = (lstat_u == dlms_pkg::STAT_HOMED) && (rstat_u == dlms_pkg::STAT_HOMED) &&
                       (pos_hi <= dlms_pkg::RECAL_HEIGHT);

    // Command window: within span of both legs and inside the desk range.
    assign lo_span     = {1'b0, pos_lo} + {5'd0, cfg.span};
    assign lowest_span = {1'b0, cfg.lowest} + {5'd0, cfg.span};
    assign clamp_top   = (lo_span < {1'b0, cfg.highest}) ? lo_span[15:0] : cfg.highest;
    assign clamp_bot   = ({1'b0, pos_hi} > lowest_span) ? (pos_hi - {4'd0, cfg.span})
                                                        : cfg.lowest;
    assign clamped     = (target_adj < clamp_bot) ? clamp_bot :
                         (target_adj > clamp_top) ? clamp_top : target_adj;

    // Next state.
    always_comb
    begin
        state_next              = state;
        state_next.left_pos     = lpos_u;
        state_next.right_pos    = rpos_u;
        state_next.left_stat    = lstat_u;
        state_next.right_stat   = rstat_u;
        state_next.last_move_ms = last_u;
        case (item.func)
            dlms_pkg::FUNC_POLL:
            begin
                if (step)
                begin
                    case (state.mode)
                        dlms_pkg::MODE_PREPARE:
                        begin
                            if (below || above)
                            begin
                                state_next.target       = target_adj;
                                state_next.last_move_ms = item.now_ms;
                                state_next.mode = below ? dlms_pkg::MODE_DOWN : dlms_pkg::MODE_UP;
                            end
                            else
                            begin
                                state_next.pending = 1'b0;
                                state_next.mode    = dlms_pkg::MODE_IDLE;
                            end
                        end
                        dlms_pkg::MODE_DOWN:
                        begin
                            if (down_stop)
                            begin
                                state_next.mode = dlms_pkg::MODE_STOP;
                            end
                        end
                        dlms_pkg::MODE_UP:
                        begin
                            if (up_stop)
                            begin
                                state_next.mode = dlms_pkg::MODE_STOP;
                            end
                        end
                        dlms_pkg::MODE_STOP:
                        begin
                            state_next.mode = dlms_pkg::MODE_DONE;
                        end
                        dlms_pkg::MODE_DONE:
                        begin
                            if (idle_u)
                            begin
                                state_next.pending = 1'b0;
                                state_next.mode    = dlms_pkg::MODE_IDLE;
                            end
                        end
                        dlms_pkg::MODE_RCPREP:
                        begin
                            state_next.mode = dlms_pkg::MODE_RCRUN;
                        end
                        dlms_pkg::MODE_RCRUN:
                        begin
                            if (rc_done)
                            begin
                                state_next.mode = dlms_pkg::MODE_RCDONE;
                            end
                        end
                        dlms_pkg::MODE_RCDONE:
                        begin
                            state_next.mode = dlms_pkg::MODE_IDLE;
                        end
                        default:
                        begin
                            state_next.mode = (state.pending && idle_u) ? dlms_pkg::MODE_PREPARE
                                                                        : dlms_pkg::MODE_IDLE;
                        end
                    endcase
                end
            end
            dlms_pkg::FUNC_TARGET:
            begin
                if ((item.new_target != 16'd0) && (item.new_target != dlms_pkg::TARGET_NONE))
                begin
                    state_next.target  = item.new_target;
                    state_next.pending = 1'b1;
                end
            end
            dlms_pkg::FUNC_RECAL:
            begin
                if (idle_s)
                begin
                    state_next.pending = 1'b0;
                    state_next.mode    = dlms_pkg::MODE_RCPREP;
                end
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

    // Result.
    always_comb
    begin
        result.cmd_valid    = 1'b0;
        result.cmd_code     = dlms_pkg::CMD_IDLE;
        result.cmd_position = 16'd0;
        if (step)
        begin
            case (state.mode)
                dlms_pkg::MODE_PREPARE:
                begin
                    if (below || above)
                    begin
                        result.cmd_valid    = 1'b1;
                        result.cmd_code     = dlms_pkg::CMD_PREMOVE;
                        result.cmd_position = clamped;
                    end
                end
                dlms_pkg::MODE_DOWN:
                begin
                    if (!down_stop)
                    begin
                        result.cmd_valid    = 1'b1;
                        result.cmd_code     = dlms_pkg::CMD_LOWER;
                        result.cmd_position = clamped;
                    end
                end
                dlms_pkg::MODE_UP:
                begin
                    if (!up_stop)
                    begin
                        result.cmd_valid    = 1'b1;
                        result.cmd_code     = dlms_pkg::CMD_RAISE;
                        result.cmd_position = clamped;
                    end
                end
                dlms_pkg::MODE_STOP:
                begin
                    result.cmd_valid    = 1'b1;
                    result.cmd_code     = dlms_pkg::CMD_OK;
                    result.cmd_position = clamped;
                end
                dlms_pkg::MODE_DONE:
                begin
                    if (!idle_u)
                    begin
                        result.cmd_valid    = 1'b1;
                        result.cmd_code     = dlms_pkg::CMD_FINISH;
                        result.cmd_position = clamped;
                    end
                end
                dlms_pkg::MODE_RCPREP:
                begin
                    result.cmd_valid    = 1'b1;
                    result.cmd_code     = dlms_pkg::CMD_PREMOVE;
                    result.cmd_position = clamped;
                end
                dlms_pkg::MODE_RCRUN:
                begin
                    if (!rc_done)
                    begin
                        result.cmd_valid = 1'b1;
                        result.cmd_code  = dlms_pkg::CMD_CALBEGIN;
                    end
                end
                dlms_pkg::MODE_RCDONE:
                begin
                    result.cmd_valid    = 1'b1;
                    result.cmd_code     = dlms_pkg::CMD_CALEND;
                    result.cmd_position = dlms_pkg::RECAL_HEIGHT;
                end
                default:
                begin
                    if (!(state.pending && idle_u))
                    begin
                        result.cmd_valid    = 1'b1;
                        result.cmd_code     = dlms_pkg::CMD_IDLE;
                        result.cmd_position = clamped;
                    end
                end
            endcase
        end
        result.alert        = poll && !(item.left_ok && item.right_ok) && state.pending;
        result.mode         = state_next.mode;
        result.move_pending = state_next.pending;
        result.target_now   = state_next.target;
    end

endmodule

// ----- rtl/desk_lift_motion_sequencer_unit.sv -----
// An accepted item waits in the input register, and its result is then written to the result
// register that drives m_tdata. Throughput: one item per cycle while m_tready is high; the
// input register refills while the result register drains.
// Reset (rst_n low, asynchronous): both registers empty, sequencer idle with no target,
// stored leg data and move time zero, configuration registers at their default values.
module desk_lift_motion_sequencer_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // now_ms[31:0], left_ok[32], left_position[48:33], left_status[56:49], right_ok[57],
    // right_position[73:58], right_status[81:74], new_target[97:82], zero fill above
    input  logic [103:0] s_tdata,
    // func[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // cmd_valid[0], cmd_code[3:1], cmd_position[19:4], alert[20], mode[24:21],
    // move_pending[25], target_now[41:26], zero fill above
    output logic [47:0]  m_tdata,
    input  logic         cfg_write,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    logic              in_valid_reg;
    logic              in_valid_next;
    dlms_pkg::item_t   in_item_reg;
    dlms_pkg::item_t   in_item_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    dlms_pkg::result_t out_data_reg;
    dlms_pkg::result_t out_data_next;
    dlms_pkg::state_t  state_reg;
    dlms_pkg::state_t  state_next;
    dlms_pkg::cfg_t    cfg_reg;
    dlms_pkg::cfg_t    cfg_next;
    dlms_pkg::state_t  step_state;
    dlms_pkg::result_t step_result;
    logic              in_fire;
    logic              fire;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign in_fire  = s_tvalid && s_tready;

    always_comb
    begin
        in_item_next.func           = s_tuser;
        in_item_next.now_ms         = s_tdata[31:0];
        in_item_next.left_ok        = s_tdata[32];
        in_item_next.left_position  = s_tdata[48:33];
        in_item_next.left_status    = s_tdata[56:49];
        in_item_next.right_ok       = s_tdata[57];
        in_item_next.right_position = s_tdata[73:58];
        in_item_next.right_status   = s_tdata[81:74];
        in_item_next.new_target     = s_tdata[97:82];
    end

    dlms_step u_step (
        .item       (in_item_reg),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .state_next (step_state),
        .result     (step_result)
    );

    always_comb
    begin
        in_valid_next  = in_fire ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
        out_valid_next = fire ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
        out_data_next  = step_result;
        state_next     = fire ? step_state : state_reg;
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                dlms_pkg::REG_LOWEST:    cfg_next.lowest    = cfg_data;
                dlms_pkg::REG_HIGHEST:   cfg_next.highest   = cfg_data;
                dlms_pkg::REG_OVERSHOOT: cfg_next.overshoot = cfg_data[9:0];
                dlms_pkg::REG_SPAN:      cfg_next.span      = cfg_data[11:0];
                dlms_pkg::REG_TIMEOUT:   cfg_next.timeout   = cfg_data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg           <= 1'b0;
            out_valid_reg          <= 1'b0;
            state_reg.mode         <= dlms_pkg::MODE_IDLE;
            state_reg.pending      <= 1'b0;
            state_reg.target       <= 16'd0;
            state_reg.left_pos     <= 16'd0;
            state_reg.right_pos    <= 16'd0;
            state_reg.left_stat    <= 8'd0;
            state_reg.right_stat   <= 8'd0;
            state_reg.last_move_ms <= 32'd0;
            cfg_reg.lowest         <= dlms_pkg::LOWEST_RESET;
            cfg_reg.highest        <= dlms_pkg::HIGHEST_RESET;
            cfg_reg.overshoot      <= dlms_pkg::OVERSHOOT_RESET;
            cfg_reg.span           <= dlms_pkg::SPAN_RESET;
            cfg_reg.timeout        <= dlms_pkg::TIMEOUT_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
            cfg_reg       <= cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_item_reg <= in_item_next;
        end
        if (fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0,
                       out_data_reg.target_now,
                       out_data_reg.move_pending,
                       out_data_reg.mode,
                       out_data_reg.alert,
                       out_data_reg.cmd_position,
                       out_data_reg.cmd_code,
                       out_data_reg.cmd_valid};

    // A result without a command carries neither a code nor a position.
    a_no_cmd_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[19:1] == 19'd0))
        else $error("result without command has nonzero code or position");

    // The prepare state is only ever reached with a move requested.
    a_prepare_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.mode == dlms_pkg::MODE_PREPARE) |-> state_reg.pending)
        else $error("prepare state without pending move");

    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed item produced no result");

    a_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !fire) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("waiting item lost or changed");

endmodule
